// ===== rtl/arcball_drag_rotation_unit_assert.svh =====
// Assertion macros for the arcball drag rotation unit.
// Each expects i_clk and i_rst_n in the scope of the use.
`ifndef ARCBALL_DRAG_ROTATION_UNIT_ASSERT_SVH
`define ARCBALL_DRAG_ROTATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ADRU_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arcball unit: assertion failed");

// Next-cycle implication.
`define ADRU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arcball unit: assertion failed");

`endif

// ===== rtl/adru_pkg.sv =====
`default_nettype none

package adru_pkg;

    localparam int FRAC_BITS = 14;
    localparam int WIN_W     = 13;
    localparam int RAD_W     = 16;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 3;
    localparam int MOUSE_W   = 14;
    localparam int QUAT_W    = 16;
    localparam int PT_W      = 16;
    localparam int D_W       = 17;
    localparam int OPN_W     = 19;
    localparam int ACC_W     = 40;
    localparam int S_W       = 37;
    localparam int STEP_W    = 5;

    localparam logic [QUAT_W-1:0] Q_ONE = QUAT_W'(1 << FRAC_BITS);
    localparam logic [STEP_W-1:0] PROD_FIRST_STEP = STEP_W'(3);

    typedef enum logic [1:0] {
        ACT_BEGIN,
        ACT_MOVE,
        ACT_END,
        ACT_RESET
    } t_action;

    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_RADIUS
    } t_cfg_idx;

    typedef enum logic {
        ITU_DIV,
        ITU_SQRT
    } t_itu_mode;

    typedef struct packed {
        logic      start;
        t_itu_mode mode;
    } t_itu_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC_MAP,
        S_SQRT,
        S_DIV_X,
        S_DIV_Y,
        S_DIV_Z,
        S_POINT,
        S_MAC_PROD,
        S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_DX, OP_DY, OP_R,
        OP_A0, OP_A1, OP_A2,
        OP_C0, OP_C1, OP_C2,
        OP_Q0, OP_Q1, OP_Q2, OP_Q3,
        OP_D0, OP_D1, OP_D2, OP_D3
    } t_opnd;

    typedef enum logic [3:0] {
        MD_NONE, MD_S, MD_R2,
        MD_D0, MD_D1, MD_D2, MD_D3,
        MD_N0, MD_N1, MD_N2, MD_N3
    } t_mdst;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  neg;
        logic  first;
        logic  last;
        t_mdst dst;
    } t_mac_op;

    function automatic t_mac_op mk_op(t_opnd a, t_opnd b, logic neg, logic first,
                                      logic last, t_mdst dst);
        t_mac_op o;
        o.a     = a;
        o.b     = b;
        o.neg   = neg;
        o.first = first;
        o.last  = last;
        o.dst   = dst;
        return o;
    endfunction

    function automatic t_mac_op mac_op(logic [STEP_W-1:0] step);
        t_mac_op o;
        case (step)
            5'd0:  o = mk_op(OP_DX, OP_DX, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd1:  o = mk_op(OP_DY, OP_DY, 1'b0, 1'b0, 1'b1, MD_S);
            5'd2:  o = mk_op(OP_R,  OP_R,  1'b0, 1'b1, 1'b1, MD_R2);
            5'd3:  o = mk_op(OP_A0, OP_C0, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd4:  o = mk_op(OP_A1, OP_C1, 1'b0, 1'b0, 1'b0, MD_NONE);
            5'd5:  o = mk_op(OP_A2, OP_C2, 1'b0, 1'b0, 1'b1, MD_D0);
            5'd6:  o = mk_op(OP_A1, OP_C2, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd7:  o = mk_op(OP_A2, OP_C1, 1'b1, 1'b0, 1'b1, MD_D1);
            5'd8:  o = mk_op(OP_A2, OP_C0, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd9:  o = mk_op(OP_A0, OP_C2, 1'b1, 1'b0, 1'b1, MD_D2);
            5'd10: o = mk_op(OP_A0, OP_C1, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd11: o = mk_op(OP_A1, OP_C0, 1'b1, 1'b0, 1'b1, MD_D3);
            5'd12: o = mk_op(OP_Q0, OP_D0, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd13: o = mk_op(OP_Q1, OP_D1, 1'b1, 1'b0, 1'b0, MD_NONE);
            5'd14: o = mk_op(OP_Q2, OP_D2, 1'b1, 1'b0, 1'b0, MD_NONE);
            5'd15: o = mk_op(OP_Q3, OP_D3, 1'b1, 1'b0, 1'b1, MD_N0);
            5'd16: o = mk_op(OP_Q0, OP_D1, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd17: o = mk_op(OP_Q1, OP_D0, 1'b0, 1'b0, 1'b0, MD_NONE);
            5'd18: o = mk_op(OP_Q2, OP_D3, 1'b0, 1'b0, 1'b0, MD_NONE);
            5'd19: o = mk_op(OP_Q3, OP_D2, 1'b1, 1'b0, 1'b1, MD_N1);
            5'd20: o = mk_op(OP_Q0, OP_D2, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd21: o = mk_op(OP_Q1, OP_D3, 1'b1, 1'b0, 1'b0, MD_NONE);
            5'd22: o = mk_op(OP_Q2, OP_D0, 1'b0, 1'b0, 1'b0, MD_NONE);
            5'd23: o = mk_op(OP_Q3, OP_D1, 1'b0, 1'b0, 1'b1, MD_N2);
            5'd24: o = mk_op(OP_Q0, OP_D3, 1'b0, 1'b1, 1'b0, MD_NONE);
            5'd25: o = mk_op(OP_Q1, OP_D2, 1'b0, 1'b0, 1'b0, MD_NONE);
            5'd26: o = mk_op(OP_Q2, OP_D1, 1'b1, 1'b0, 1'b0, MD_NONE);
            5'd27: o = mk_op(OP_Q3, OP_D0, 1'b0, 1'b0, 1'b1, MD_N3);
            default: o = mk_op(OP_R, OP_R, 1'b0, 1'b1, 1'b1, MD_NONE);
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/arcball_drag_rotation_unit.sv =====
// Channel | Direction | Handshake                    | Payload
// in      | input     | i_in_valid / o_in_stall      | i_action, i_mouse_x, i_mouse_y
// out     | output    | o_out_valid / i_out_stall    | o_quat_w/x/y/z, o_dragging
// cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// End, reset and ignored events skip the arithmetic. A begin or move takes a root and two
// divides (three inside the ball) on the bit-serial divide/root unit (32 root steps, 16 per
// divide); a move also runs 25 products on the single multiply-accumulate.
// One event at a time; the next transfer is taken once the result sits in the
// output register, which holds it while i_out_stall is high.
// Reset is synchronous, active low, and restores the control and configuration registers and identity rotation.
`default_nettype none

module arcball_drag_rotation_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [13:0] i_mouse_x,
    input  wire logic [13:0] i_mouse_y,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_quat_w,
    output logic [15:0]      o_quat_x,
    output logic [15:0]      o_quat_y,
    output logic [15:0]      o_quat_z,
    output logic             o_dragging,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import adru_pkg::*;
    `include "arcball_drag_rotation_unit_assert.svh"

    logic [WIN_W-1:0]         r_cfg_w, r_cfg_h, r_cx, r_cy;
    logic [RAD_W-1:0]         r_rad;
    t_state                   r_state, n_state;
    logic [STEP_W-1:0]        r_step;
    logic                     r_launched;
    t_action                  r_act;
    logic signed [OPN_W-1:0]  r_dx, r_dy;
    logic signed [ACC_W-1:0]  r_acc;
    logic [S_W-1:0]           r_s;
    logic [31:0]              r_r2;
    logic [31:0]              r_len;
    logic signed [PT_W-1:0]   r_p [3];
    logic signed [PT_W-1:0]   r_a [3];
    logic signed [QUAT_W-1:0] r_sq [4];
    logic signed [QUAT_W-1:0] r_nq [4];
    logic signed [D_W-1:0]    r_d [4];
    logic                     r_drag;
    logic                     r_ov;
    logic [QUAT_W-1:0]        r_oq [4];
    logic                     r_odrag;

    t_action                  act_in;
    logic                     in_xfer, in_win;
    logic signed [OPN_W-1:0]  mx2, my2, dfx, dfy;
    logic [RAD_W-1:0]         rad;
    logic [OPN_W-1:0]         adx_f, ady_f;
    logic [17:0]              adx, ady, dsel;
    logic                     rim, dneg;

    t_mac_op                  op;
    logic signed [OPN_W-1:0]  op_a, op_b;
    logic signed [37:0]       prod;
    logic signed [ACC_W-1:0]  prod_x, term, acc_next;
    logic [ACC_W-1:0]         acc_mag, acc_rnd;
    logic [25:0]              rnd;
    logic signed [26:0]       rs;
    logic signed [QUAT_W-1:0] sat_q;

    t_itu_req                 itu_req;
    logic [63:0]              itu_num;
    logic [31:0]              itu_den, itu_res;
    logic                     itu_done;
    logic signed [PT_W-1:0]   qpt;
    logic                     out_load, mac_run;
    logic                     pt_ok;

    assign act_in  = t_action'(i_action);
    assign in_xfer = i_in_valid && !o_in_stall;
    assign in_win  = !i_mouse_x[13] && (i_mouse_x[12:0] < r_cfg_w) &&
                     !i_mouse_y[13] && (i_mouse_y[12:0] < r_cfg_h);
    assign mx2     = {{4{i_mouse_x[13]}}, i_mouse_x, 1'b0};
    assign my2     = {{4{i_mouse_y[13]}}, i_mouse_y, 1'b0};
    assign dfx     = $signed({6'd0, r_cx}) - mx2;
    assign dfy     = $signed({6'd0, r_cy}) - my2;

    assign rad   = (r_rad == '0) ? RAD_W'(1) : r_rad;
    assign adx_f = r_dx[OPN_W-1] ? -r_dx : r_dx;
    assign ady_f = r_dy[OPN_W-1] ? -r_dy : r_dy;
    assign adx   = adx_f[17:0];
    assign ady   = ady_f[17:0];
    assign rim   = r_s > {5'd0, r_r2};

    function automatic logic signed [OPN_W-1:0] pick(t_opnd sel);
        logic signed [OPN_W-1:0] v;
        case (sel)
            OP_DX:   v = r_dx;
            OP_DY:   v = r_dy;
            OP_R:    v = $signed({3'd0, rad});
            OP_A0:   v = OPN_W'(r_a[0]);
            OP_A1:   v = OPN_W'(r_a[1]);
            OP_A2:   v = OPN_W'(r_a[2]);
            OP_C0:   v = OPN_W'(r_p[0]);
            OP_C1:   v = OPN_W'(r_p[1]);
            OP_C2:   v = OPN_W'(r_p[2]);
            OP_Q0:   v = OPN_W'(r_sq[0]);
            OP_Q1:   v = OPN_W'(r_sq[1]);
            OP_Q2:   v = OPN_W'(r_sq[2]);
            OP_Q3:   v = OPN_W'(r_sq[3]);
            OP_D0:   v = OPN_W'(r_d[0]);
            OP_D1:   v = OPN_W'(r_d[1]);
            OP_D2:   v = OPN_W'(r_d[2]);
            OP_D3:   v = OPN_W'(r_d[3]);
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        op       = mac_op(r_step);
        op_a     = pick(op.a);
        op_b     = pick(op.b);
        prod     = op_a * op_b;
        prod_x   = ACC_W'(prod);
        term     = op.neg ? -prod_x : prod_x;
        acc_next = (op.first ? '0 : r_acc) + term;
        acc_mag  = acc_next[ACC_W-1] ? -acc_next : acc_next;
        acc_rnd  = acc_mag + (ACC_W'(1) << (FRAC_BITS - 1));
        rnd      = acc_rnd[ACC_W-1:FRAC_BITS];
        rs       = acc_next[ACC_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        if (rs > 27'sd32767) begin
            sat_q = 16'sh7FFF;
        end else if (rs < -27'sd32768) begin
            sat_q = 16'sh8000;
        end else begin
            sat_q = rs[15:0];
        end
    end

    always_comb begin
        dsel    = (r_state == S_DIV_Y) ? ady : adx;
        itu_num = '0;
        itu_den = '0;
        case (r_state)
            S_SQRT: begin
                if (rim) begin
                    itu_num = {7'd0, r_s, 20'd0};
                end else begin
                    itu_num = {2'd0, r_r2 - r_s[31:0], 30'd0};
                end
            end
            S_DIV_X, S_DIV_Y: begin
                if (rim) begin
                    itu_num = ({46'd0, dsel} << (FRAC_BITS + 10)) + {33'd0, r_len[31:1]};
                    itu_den = r_len;
                end else begin
                    itu_num = ({46'd0, dsel} << FRAC_BITS) + {49'd0, rad[RAD_W-1:1]};
                    itu_den = {16'd0, rad};
                end
            end
            S_DIV_Z: begin
                itu_num = ({32'd0, r_len} << FRAC_BITS) + ({48'd0, rad} << FRAC_BITS);
                itu_den = {1'b0, rad, 15'd0};
            end
            default: begin
                itu_num = '0;
            end
        endcase
    end

    always_comb begin
        dneg = (r_state == S_DIV_Y) ? r_dy[OPN_W-1] : r_dx[OPN_W-1];
        if (r_state == S_DIV_Z) begin
            dneg = 1'b0;
        end
        qpt = dneg ? -$signed(itu_res[15:0]) : $signed(itu_res[15:0]);
    end

    adru_itu u_itu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (itu_req),
        .i_num   (itu_num),
        .i_den   (itu_den),
        .o_done  (itu_done),
        .o_res   (itu_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if ((act_in == ACT_BEGIN && in_win) || (act_in == ACT_MOVE && r_drag)) begin
                        n_state = S_MAC_MAP;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_MAC_MAP: begin
                if (op.last && op.dst == MD_R2) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (itu_done) begin
                    n_state = S_DIV_X;
                end
            end
            S_DIV_X: begin
                if (itu_done) begin
                    n_state = S_DIV_Y;
                end
            end
            S_DIV_Y: begin
                if (itu_done) begin
                    n_state = rim ? S_POINT : S_DIV_Z;
                end
            end
            S_DIV_Z: begin
                if (itu_done) begin
                    n_state = S_POINT;
                end
            end
            S_POINT: begin
                n_state = (r_act == ACT_BEGIN) ? S_FINISH : S_MAC_PROD;
            end
            S_MAC_PROD: begin
                if (op.last && op.dst == MD_N3) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_ov || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        itu_req.start = 1'b0;
        itu_req.mode  = ITU_DIV;
        out_load      = 1'b0;
        mac_run       = 1'b0;
        case (r_state)
            S_SQRT: begin
                itu_req.start = !r_launched;
                itu_req.mode  = ITU_SQRT;
            end
            S_DIV_X, S_DIV_Y, S_DIV_Z: begin
                itu_req.start = !r_launched;
            end
            S_MAC_MAP, S_MAC_PROD: begin
                mac_run = 1'b1;
            end
            S_FINISH: begin
                out_load = !r_ov || !i_out_stall;
            end
            default: begin
                mac_run = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
            r_ov       <= 1'b0;
            r_drag     <= 1'b0;
            r_cfg_w    <= WIN_W'(1024);
            r_cfg_h    <= WIN_W'(768);
            r_cx       <= WIN_W'(1024);
            r_cy       <= WIN_W'(768);
            r_rad      <= RAD_W'(5837);
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= (i == 0) ? Q_ONE : '0;
                r_nq[i] <= (i == 0) ? Q_ONE : '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (itu_req.start) begin
                r_launched <= 1'b1;
            end else if (itu_done) begin
                r_launched <= 1'b0;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:    r_cfg_w <= i_cfg_data[WIN_W-1:0];
                    CFG_HEIGHT:   r_cfg_h <= i_cfg_data[WIN_W-1:0];
                    CFG_CENTER_X: r_cx    <= i_cfg_data[WIN_W-1:0];
                    CFG_CENTER_Y: r_cy    <= i_cfg_data[WIN_W-1:0];
                    CFG_RADIUS:   r_rad   <= i_cfg_data;
                    default:      r_rad   <= r_rad;
                endcase
            end
            if (in_xfer) begin
                case (act_in)
                    ACT_END: begin
                        r_drag <= 1'b0;
                    end
                    ACT_RESET: begin
                        r_drag <= 1'b0;
                        for (int i = 0; i < 4; i++) begin
                            r_sq[i] <= (i == 0) ? Q_ONE : '0;
                            r_nq[i] <= (i == 0) ? Q_ONE : '0;
                        end
                    end
                    default: begin
                        r_drag <= r_drag;
                    end
                endcase
            end
            if (r_state == S_POINT && r_act == ACT_BEGIN) begin
                r_drag <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_a[i] <= r_p[i];
                end
                for (int i = 0; i < 4; i++) begin
                    r_sq[i] <= r_nq[i];
                end
            end
            if (mac_run && op.last) begin
                case (op.dst)
                    MD_N0:   r_nq[0] <= sat_q;
                    MD_N1:   r_nq[1] <= sat_q;
                    MD_N2:   r_nq[2] <= sat_q;
                    MD_N3:   r_nq[3] <= sat_q;
                    default: r_nq[0] <= r_nq[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act <= act_in;
            r_dx  <= {dfx[15:0], 3'b000};
            r_dy  <= {dfy[15:0], 3'b000};
        end
        if (n_state == S_MAC_MAP && r_state == S_IDLE) begin
            r_step <= '0;
        end else if (r_state == S_POINT) begin
            r_step <= PROD_FIRST_STEP;
        end else if (mac_run) begin
            r_step <= r_step + STEP_W'(1);
        end
        if (mac_run) begin
            r_acc <= acc_next;
            if (op.last) begin
                case (op.dst)
                    MD_S:    r_s    <= acc_next[S_W-1:0];
                    MD_R2:   r_r2   <= acc_next[31:0];
                    MD_D0:   r_d[0] <= rs[D_W-1:0];
                    MD_D1:   r_d[1] <= rs[D_W-1:0];
                    MD_D2:   r_d[2] <= rs[D_W-1:0];
                    MD_D3:   r_d[3] <= rs[D_W-1:0];
                    default: r_s    <= r_s;
                endcase
            end
        end
        if (itu_done) begin
            case (r_state)
                S_SQRT:  r_len  <= itu_res;
                S_DIV_X: r_p[0] <= qpt;
                S_DIV_Y: begin
                    r_p[1] <= qpt;
                    if (rim) begin
                        r_p[2] <= '0;
                    end
                end
                S_DIV_Z: r_p[2] <= qpt;
                default: r_len  <= r_len;
            endcase
        end
        if (out_load) begin
            for (int i = 0; i < 4; i++) begin
                r_oq[i] <= r_nq[i];
            end
            r_odrag <= r_drag;
        end
    end

    assign o_out_valid = r_ov;
    assign o_quat_w    = r_oq[0];
    assign o_quat_x    = r_oq[1];
    assign o_quat_y    = r_oq[2];
    assign o_quat_z    = r_oq[3];
    assign o_dragging  = r_odrag;

    assign pt_ok = (r_p[0] <= 16'sd16384) && (r_p[0] >= -16'sd16384) &&
                   (r_p[1] <= 16'sd16384) && (r_p[1] >= -16'sd16384) &&
                   (r_p[2] <= 16'sd16384) && (r_p[2] >= -16'sd16384);

    `ADRU_ASSERT_IMPL(a_prod_needs_drag, r_state == S_MAC_PROD, r_drag)
    `ADRU_ASSERT_IMPL(a_itu_done_launched, itu_done, r_launched)
    `ADRU_ASSERT_IMPL(a_point_range, r_state == S_POINT, pt_ok)
    `ADRU_ASSERT_NEXT(a_out_load, out_load, o_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

// ===== rtl/adru_itu.sv =====
`default_nettype none

module adru_itu (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire adru_pkg::t_itu_req  i_req,
    input  wire logic [63:0]         i_num,
    input  wire logic [31:0]         i_den,
    output logic                     o_done,
    output logic [31:0]              o_res
);
    import adru_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_itu_mode   r_mode;
    logic [4:0]  r_cnt;
    logic [34:0] r_rem;
    logic [63:0] r_val;
    logic [31:0] r_res;
    logic [31:0] r_den;

    logic [34:0] x;
    logic [34:0] y;
    logic [35:0] diff;
    logic        ge;

    always_comb begin
        if (r_mode == ITU_SQRT) begin
            x = {r_rem[32:0], r_val[63:62]};
            y = {1'b0, r_res, 2'b01};
        end else begin
            x = {2'b00, r_rem[31:0], r_val[63]};
            y = {3'b000, r_den};
        end
        diff = {1'b0, x} - {1'b0, y};
        ge   = ~diff[35];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_den  <= i_den;
            r_res  <= 32'd0;
            if (i_req.mode == ITU_SQRT) begin
                r_cnt <= 5'd31;
                r_rem <= 35'd0;
                r_val <= i_num;
            end else begin
                r_cnt <= 5'd15;
                r_rem <= {3'b000, i_num[47:16]};
                r_val <= {i_num[15:0], 48'd0};
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff[34:0] : x;
            r_res <= {r_res[30:0], ge};
            r_val <= (r_mode == ITU_SQRT) ? {r_val[61:0], 2'b00} : {r_val[62:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== dv/tb_arcball_drag_rotation_unit.sv =====
`default_nettype none

module tb_arcball_drag_rotation_unit;
    import adru_pkg::*;

    typedef struct {
        t_action     act;
        logic [13:0] x;
        logic [13:0] y;
    } t_event;

    typedef struct {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        drag;
    } t_pose;

    typedef longint t_vec3 [3];
    typedef longint t_quat [4];

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [13:0] i_mouse_x;
    logic [13:0] i_mouse_y;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_quat_w;
    logic [15:0] o_quat_x;
    logic [15:0] o_quat_y;
    logic [15:0] o_quat_z;
    logic        o_dragging;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    arcball_drag_rotation_unit u_dut (.*);

    t_event event_q[$];
    t_pose  pose_q[$];
    t_event cur_ev;
    int     in_gap;
    int     out_gap;
    bit     busy_mode;
    int     errors;

    longint unsigned win_w, win_h, ctr_x, ctr_y, radius;
    bit     drag_on;
    t_quat  anchor_quat;
    t_quat  rot_quat;
    t_vec3  anchor_pt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint with_sign(bit neg, longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint rdiv(longint num, longint unsigned den);
        return with_sign(num < 0, (magn(num) + den / 2) / den);
    endfunction

    function automatic longint rshift_frac(longint v);
        return with_sign(v < 0, (magn(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_vec3 sphere_point(longint mx, longint my);
        t_vec3 p;
        longint unsigned r, r2, s, len, root, den;
        longint dx, dy;
        r  = radius != 0 ? radius : 1;
        dx = (longint'(ctr_x) - 2 * mx) * 8;
        dy = (longint'(ctr_y) - 2 * my) * 8;
        s  = magn(dx) * magn(dx) + magn(dy) * magn(dy);
        r2 = r * r;
        if (s > r2) begin
            len  = int_sqrt(s << 20);
            p[0] = with_sign(dx < 0, ((magn(dx) << (FRAC_BITS + 10)) + len / 2) / len);
            p[1] = with_sign(dy < 0, ((magn(dy) << (FRAC_BITS + 10)) + len / 2) / len);
            p[2] = 0;
        end else begin
            root = int_sqrt((r2 - s) << 30);
            den  = r << 15;
            p[0] = rdiv(dx * (64'd1 << FRAC_BITS), r);
            p[1] = rdiv(dy * (64'd1 << FRAC_BITS), r);
            p[2] = longint'(((root << FRAC_BITS) + den / 2) / den);
        end
        return p;
    endfunction

    function automatic t_quat unit_quat();
        t_quat q;
        q[0] = clamp16(64'd1 << FRAC_BITS);
        q[1] = 0;
        q[2] = 0;
        q[3] = 0;
        return q;
    endfunction

    function automatic t_pose apply_event(t_event ev);
        t_pose  res;
        t_vec3  a, c;
        t_quat  q, d;
        longint mx, my;
        mx = longint'($signed(ev.x));
        my = longint'($signed(ev.y));
        case (ev.act)
            ACT_BEGIN: begin
                if (mx >= 0 && mx < longint'(win_w) && my >= 0 && my < longint'(win_h)) begin
                    drag_on = 1'b1;
                    anchor_quat = rot_quat;
                    anchor_pt = sphere_point(mx, my);
                end
            end
            ACT_MOVE: begin
                if (drag_on) begin
                    a = anchor_pt;
                    q = anchor_quat;
                    c = sphere_point(mx, my);
                    d[0] = rshift_frac(a[0] * c[0] + a[1] * c[1] + a[2] * c[2]);
                    d[1] = rshift_frac(a[1] * c[2] - a[2] * c[1]);
                    d[2] = rshift_frac(a[2] * c[0] - a[0] * c[2]);
                    d[3] = rshift_frac(a[0] * c[1] - a[1] * c[0]);
                    rot_quat[0] = clamp16(rshift_frac(q[0] * d[0] - q[1] * d[1]
                                                    - q[2] * d[2] - q[3] * d[3]));
                    rot_quat[1] = clamp16(rshift_frac(q[0] * d[1] + q[1] * d[0]
                                                    + q[2] * d[3] - q[3] * d[2]));
                    rot_quat[2] = clamp16(rshift_frac(q[0] * d[2] - q[1] * d[3]
                                                    + q[2] * d[0] + q[3] * d[1]));
                    rot_quat[3] = clamp16(rshift_frac(q[0] * d[3] + q[1] * d[2]
                                                    - q[2] * d[1] + q[3] * d[0]));
                end
            end
            ACT_END: drag_on = 1'b0;
            default: begin
                anchor_quat = unit_quat();
                rot_quat = unit_quat();
                drag_on = 1'b0;
            end
        endcase
        res.w = rot_quat[0][15:0];
        res.x = rot_quat[1][15:0];
        res.y = rot_quat[2][15:0];
        res.z = rot_quat[3][15:0];
        res.drag = drag_on;
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        if (!busy_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) pose_q.push_back(apply_event(cur_ev));
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    cur_ev = event_q.pop_front();
                    i_action <= cur_ev.act;
                    i_mouse_x <= cur_ev.x;
                    i_mouse_y <= cur_ev.y;
                    i_in_valid <= 1'b1;
                    in_gap = idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_pose exp_p;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pose_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer on output");
            end else begin
                exp_p = pose_q.pop_front();
                if (exp_p.w !== o_quat_w || exp_p.x !== o_quat_x || exp_p.y !== o_quat_y
                        || exp_p.z !== o_quat_z || exp_p.drag !== o_dragging) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                                 exp_p.w, exp_p.x, exp_p.y, exp_p.z, exp_p.drag,
                                 o_quat_w, o_quat_x, o_quat_y, o_quat_z, o_dragging);
                end
            end
        end
        if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            out_gap = idle_len();
            i_out_stall <= out_gap > 0;
        end
    end

    task automatic push_event(t_action act, int x, int y);
        t_event ev;
        ev.act = act;
        ev.x = 14'(x);
        ev.y = 14'(y);
        event_q.push_back(ev);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIDTH:    win_w = value & 16'h1FFF;
            CFG_HEIGHT:   win_h = value & 16'h1FFF;
            CFG_CENTER_X: ctr_x = value & 16'h1FFF;
            CFG_CENTER_Y: ctr_y = value & 16'h1FFF;
            default:      radius = value & 16'hFFFF;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk); while (event_q.size() > 0 || i_in_valid || pose_q.size() > 0);
    endtask

    task automatic random_drag();
        int n;
        int bx, by;
        if (win_w > 0 && win_h > 0) begin
            bx = $urandom_range(0, win_w - 1);
            by = $urandom_range(0, win_h - 1);
        end else begin
            bx = $urandom_range(0, 200);
            by = $urandom_range(0, 200);
        end
        push_event(ACT_BEGIN, bx, by);
        n = $urandom_range(1, 8);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                push_event(ACT_MOVE, $urandom, $urandom);
            else
                push_event(ACT_MOVE, bx + $urandom_range(0, 400) - 200,
                           by + $urandom_range(0, 400) - 200);
        end
        if ($urandom_range(0, 4) != 0) push_event(ACT_END, $urandom, $urandom);
    endtask

    initial begin
        int cfgs [7][5] = '{
            '{1024, 768, 1024, 768, 5837},
            '{1, 1, 0, 0, 16},
            '{8191, 8191, 8191, 8191, 65535},
            '{640, 480, 640, 480, 0},
            '{0, 300, 300, 300, 2000},
            '{4095, 1, 5000, 100, 900},
            '{200, 200, 200, 200, 3200}
        };
        errors = 0;
        busy_mode = 1'b1;
        out_gap = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = '0;
        i_mouse_x = '0;
        i_mouse_y = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        win_w = 1024;
        win_h = 768;
        ctr_x = 1024;
        ctr_y = 768;
        radius = 5837;
        drag_on = 1'b0;
        anchor_quat = unit_quat();
        rot_quat = unit_quat();
        anchor_pt = '{0, 0, 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_event(ACT_RESET, 0, 0);
        push_event(ACT_MOVE, 100, 100);
        push_event(ACT_END, 0, 0);
        push_event(ACT_BEGIN, -1, 10);
        push_event(ACT_BEGIN, 1024, 10);
        push_event(ACT_BEGIN, 10, 768);
        push_event(ACT_BEGIN, -8192, -8192);
        push_event(ACT_BEGIN, 0, 0);
        push_event(ACT_MOVE, 1023, 767);
        push_event(ACT_MOVE, 512, 384);
        push_event(ACT_MOVE, 8191, -8192);
        push_event(ACT_MOVE, -8192, 8191);
        push_event(ACT_BEGIN, 1023, 767);
        push_event(ACT_MOVE, 600, 300);
        push_event(ACT_BEGIN, 500, 400);
        push_event(ACT_MOVE, 520, 380);
        push_event(ACT_END, 8191, 8191);
        push_event(ACT_MOVE, 700, 700);
        push_event(ACT_BEGIN, 512, 384);
        push_event(ACT_MOVE, 900, 100);
        push_event(ACT_RESET, -1, -1);
        push_event(ACT_MOVE, 1, 1);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(CFG_WIDTH, cfgs[ph][0]);
            write_reg(CFG_HEIGHT, cfgs[ph][1]);
            write_reg(CFG_CENTER_X, cfgs[ph][2]);
            write_reg(CFG_CENTER_Y, cfgs[ph][3]);
            write_reg(CFG_RADIUS, cfgs[ph][4]);
            busy_mode = (ph % 3) != 2;
            while (event_q.size() < 230) begin
                if ($urandom_range(0, 9) < 8)
                    random_drag();
                else
                    push_event(t_action'($urandom_range(0, 3)), $urandom, $urandom);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== arcball_drag_rotation_unit.f =====
+incdir+rtl
rtl/adru_pkg.sv
rtl/adru_itu.sv
rtl/arcball_drag_rotation_unit.sv
dv/tb_arcball_drag_rotation_unit.sv
